// ===== src/fprs_pkg.sv =====
package fprs_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int ITER_BITS = 16;
   localparam int CALL_BITS = 17;
   localparam int ABS_TOL_BITS = 31;
   localparam int REL_TOL_BITS = 16;
   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   // register indexes (word address)
   localparam logic [1:0] REG_ABS_TOL = 2'd0;
   localparam logic [1:0] REG_REL_TOL = 2'd1;
   localparam logic [1:0] REG_ITER_LIMIT = 2'd2;

   localparam logic [ABS_TOL_BITS-1:0] ABS_TOL_RESET = 31'd66;
   localparam logic [REL_TOL_BITS-1:0] REL_TOL_RESET = 16'd66;
   localparam logic [ITER_BITS-1:0] ITER_LIMIT_RESET = 16'd100;

   // action codes
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_VALUE = 1'b1;

   // result kinds
   localparam logic KIND_PROBE = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // status codes
   localparam logic [2:0] STAT_PROGRESS = 3'd0;
   localparam logic [2:0] STAT_CONVERGED = 3'd1;
   localparam logic [2:0] STAT_SIGN_ERROR = 3'd2;
   localparam logic [2:0] STAT_NO_CONV = 3'd3;
   localparam logic [2:0] STAT_ORDER = 3'd4;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT_A,
      PH_WAIT_B,
      PH_WAIT_M
   } phase_type;

   typedef enum logic [2:0] {
      ST_READY,
      ST_MUL,
      ST_DIV,
      ST_RELMUL,
      ST_EMIT
   } ctrl_state_type;

   // magnitude of a signed word, as unsigned of the same width
   function automatic logic [WORD_BITS-1:0] mag_word(input logic [WORD_BITS-1:0] v);
      mag_word = v[WORD_BITS-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

// ===== src/false_position_root_search_top.sv =====
// Bracketed false-position root search in Q16.16.
// Input channel (req_): a start item (action 0) brings the bracket ends; each
// value item (action 1) returns f at the point that was last asked for.
// Result channel (rsp_): one item per input item, either a request to
// evaluate f at rsp_point (kind 0) or the final answer (kind 1) with status.
// Registers on the csr_ port: abs tolerance, rel tolerance, iteration limit.
// A start or a first end value passes the result stage and then the result
// register on its way to rsp_valid. A value that leads to an interpolation
// runs the bit-serial multiplier for |dx|*|fa|, then the bit-serial divider,
// and its result is then loaded; a value after a probe first runs the
// multiplier on the relative tolerance product.
// One item is worked on at a time; the input is ready again once its result
// is loaded. The result register lets the next item be accepted while a
// result still waits; if the receiver stalls, the block holds the finished
// result and stops accepting after the following one is ready.
// Reset (synchronous) returns to idle, clears the search state and loads
// the register defaults.
module false_position_root_search_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic signed [31:0]                 req_bracket_low,
   input  logic signed [31:0]                 req_bracket_high,
   input  logic signed [31:0]                 req_f_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_kind,
   output logic signed [31:0]                 rsp_point,
   output logic [2:0]                         rsp_status,
   output logic [15:0]                        rsp_iterations_done,
   output logic [16:0]                        rsp_function_calls,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fprs_pkg::ADDR_BITS-1:0]     csr_paddr,
   input  logic [fprs_pkg::DATA_BITS-1:0]     csr_pwdata,
   output logic [fprs_pkg::DATA_BITS-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import fprs_pkg::*;

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;

   logic [WORD_BITS-1:0] end_a_ff, end_a_in;
   logic [WORD_BITS-1:0] end_b_ff, end_b_in;
   logic [WORD_BITS-1:0] value_a_ff, value_a_in;
   logic [WORD_BITS-1:0] value_b_ff, value_b_in;
   logic [WORD_BITS-1:0] probe_ff, probe_in;
   logic                 fm_zero_ff, fm_zero_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;
   logic [CALL_BITS-1:0] calls_ff, calls_in;

   logic [ABS_TOL_BITS-1:0] abs_tol_ff;
   logic [REL_TOL_BITS-1:0] rel_tol_ff;
   logic [ITER_BITS-1:0]    iter_limit_ff;

   logic                 res_kind_ff, res_kind_in;
   logic [WORD_BITS-1:0] res_point_ff, res_point_in;
   logic [2:0]           res_status_ff, res_status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff;
   logic [WORD_BITS-1:0] rsp_point_ff;
   logic [2:0]           rsp_status_ff;
   logic [ITER_BITS-1:0] rsp_iter_ff;
   logic [CALL_BITS-1:0] rsp_calls_ff;
   logic                 load_rsp;

   logic                 mul_start, mul_rel, mul_done;
   logic [WORD_BITS-1:0] mul_a, mul_b;
   logic [PROD_BITS-1:0] mul_product;
   logic                 div_start, div_done;
   logic [WORD_BITS-1:0] div_quotient;

   logic [WORD_BITS:0]   dx;
   logic [WORD_BITS-1:0] dx_mag;
   logic [WORD_BITS-1:0] fa_mag, fb_mag;
   logic [WORD_BITS:0]   den;
   logic [WORD_BITS-1:0] new_point;
   logic                 converged;
   logic                 csr_write;

   // bracket width, magnitudes and interpolated point
   assign dx = {end_b_ff[WORD_BITS-1], end_b_ff} - {end_a_ff[WORD_BITS-1], end_a_ff};
   assign dx_mag = dx[WORD_BITS] ? WORD_BITS'(~dx + 1'b1) : dx[WORD_BITS-1:0];
   assign fa_mag = mag_word(value_a_ff);
   assign fb_mag = mag_word(value_b_ff);
   assign den = {1'b0, fa_mag} + {1'b0, fb_mag};
   always_comb begin
      if (den == '0) begin
         new_point = end_a_ff;
      end else if (dx[WORD_BITS]) begin
         new_point = end_a_ff - div_quotient;
      end else begin
         new_point = end_a_ff + div_quotient;
      end
   end

   // convergence after a probe value
   assign converged = fm_zero_ff
      || ({1'b0, dx_mag} < {2'b0, abs_tol_ff})
      || ({dx_mag, {FRAC_BITS{1'b0}}} < mul_product[WORD_BITS+FRAC_BITS-1:0]);

   // multiplier operands: rel product or interpolation product
   assign mul_a = mul_rel ? {{(WORD_BITS-REL_TOL_BITS){1'b0}}, rel_tol_ff} : dx_mag;
   assign mul_b = mul_rel ? mag_word(probe_ff) : fa_mag;

   fprs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   fprs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_product),
      .divisor  (den),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready = (state_ff == ST_READY);
   assign load_rsp = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // control sequencer
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      end_a_in = end_a_ff;
      end_b_in = end_b_ff;
      value_a_in = value_a_ff;
      value_b_in = value_b_ff;
      probe_in = probe_ff;
      fm_zero_in = fm_zero_ff;
      iter_in = iter_ff;
      calls_in = calls_ff;
      res_kind_in = res_kind_ff;
      res_point_in = res_point_ff;
      res_status_in = res_status_ff;
      mul_start = 1'b0;
      mul_rel = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_READY: begin
            if (req_valid) begin
               state_in = ST_EMIT;
               res_kind_in = KIND_PROBE;
               res_status_in = STAT_PROGRESS;
               if (req_action == ACT_START) begin
                  end_a_in = req_bracket_low;
                  end_b_in = req_bracket_high;
                  value_a_in = '0;
                  value_b_in = '0;
                  probe_in = '0;
                  iter_in = '0;
                  calls_in = CALL_BITS'(1);
                  phase_in = PH_WAIT_A;
                  res_point_in = req_bracket_low;
               end else begin
                  case (phase_ff)
                     PH_WAIT_A: begin
                        value_a_in = req_f_value;
                        calls_in = CALL_BITS'(2);
                        phase_in = PH_WAIT_B;
                        res_point_in = end_b_ff;
                     end
                     PH_WAIT_B: begin
                        value_b_in = req_f_value;
                        res_kind_in = KIND_DONE;
                        phase_in = PH_IDLE;
                        if (value_a_ff == '0) begin
                           res_point_in = end_a_ff;
                           res_status_in = STAT_CONVERGED;
                        end else if (req_f_value == '0) begin
                           res_point_in = end_b_ff;
                           res_status_in = STAT_CONVERGED;
                        end else if (value_a_ff[WORD_BITS-1] == req_f_value[WORD_BITS-1]) begin
                           res_point_in = '0;
                           res_status_in = STAT_SIGN_ERROR;
                        end else if (iter_limit_ff == '0) begin
                           res_point_in = end_a_ff;
                           res_status_in = STAT_NO_CONV;
                        end else begin
                           phase_in = PH_WAIT_B;
                           iter_in = iter_ff + 1'b1;
                           mul_start = 1'b1;
                           state_in = ST_MUL;
                        end
                     end
                     PH_WAIT_M: begin
                        if (req_f_value[WORD_BITS-1] == value_b_ff[WORD_BITS-1]) begin
                           end_b_in = probe_ff;
                           value_b_in = req_f_value;
                        end else begin
                           end_a_in = probe_ff;
                           value_a_in = req_f_value;
                        end
                        fm_zero_in = (req_f_value == '0);
                        mul_start = 1'b1;
                        mul_rel = 1'b1;
                        state_in = ST_RELMUL;
                     end
                     default: begin
                        res_kind_in = KIND_DONE;
                        res_point_in = '0;
                        res_status_in = STAT_ORDER;
                     end
                  endcase
               end
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               probe_in = new_point;
               calls_in = calls_ff + 1'b1;
               phase_in = PH_WAIT_M;
               res_kind_in = KIND_PROBE;
               res_point_in = new_point;
               res_status_in = STAT_PROGRESS;
               state_in = ST_EMIT;
            end
         end
         ST_RELMUL: begin
            if (mul_done) begin
               if (converged) begin
                  res_kind_in = KIND_DONE;
                  res_point_in = probe_ff;
                  res_status_in = STAT_CONVERGED;
                  phase_in = PH_IDLE;
                  state_in = ST_EMIT;
               end else if (iter_ff >= iter_limit_ff) begin
                  res_kind_in = KIND_DONE;
                  res_point_in = end_a_ff;
                  res_status_in = STAT_NO_CONV;
                  phase_in = PH_IDLE;
                  state_in = ST_EMIT;
               end else begin
                  iter_in = iter_ff + 1'b1;
                  mul_start = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_EMIT: begin
            if (load_rsp) begin
               state_in = ST_READY;
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   // state and search registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READY;
         phase_ff <= PH_IDLE;
         end_a_ff <= '0;
         end_b_ff <= '0;
         value_a_ff <= '0;
         value_b_ff <= '0;
         probe_ff <= '0;
         iter_ff <= '0;
         calls_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         end_a_ff <= end_a_in;
         end_b_ff <= end_b_in;
         value_a_ff <= value_a_in;
         value_b_ff <= value_b_in;
         probe_ff <= probe_in;
         iter_ff <= iter_in;
         calls_ff <= calls_in;
      end
      fm_zero_ff <= fm_zero_in;
      res_kind_ff <= res_kind_in;
      res_point_ff <= res_point_in;
      res_status_ff <= res_status_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_rsp) begin
         rsp_kind_ff <= res_kind_ff;
         rsp_point_ff <= res_point_ff;
         rsp_status_ff <= res_status_ff;
         rsp_iter_ff <= iter_ff;
         rsp_calls_ff <= calls_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_point = rsp_point_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_iterations_done = rsp_iter_ff;
   assign rsp_function_calls = rsp_calls_ff;

   // configuration registers
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         abs_tol_ff <= ABS_TOL_RESET;
         rel_tol_ff <= REL_TOL_RESET;
         iter_limit_ff <= ITER_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_ABS_TOL: abs_tol_ff <= csr_pwdata[ABS_TOL_BITS-1:0];
            REG_REL_TOL: rel_tol_ff <= csr_pwdata[REL_TOL_BITS-1:0];
            REG_ITER_LIMIT: iter_limit_ff <= csr_pwdata[ITER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // register read
   always_comb begin
      case (csr_paddr[3:2])
         REG_ABS_TOL: csr_prdata = {{(DATA_BITS-ABS_TOL_BITS){1'b0}}, abs_tol_ff};
         REG_REL_TOL: csr_prdata = {{(DATA_BITS-REL_TOL_BITS){1'b0}}, rel_tol_ff};
         REG_ITER_LIMIT: csr_prdata = {{(DATA_BITS-ITER_BITS){1'b0}}, iter_limit_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

endmodule

// ===== src/fprs_mul.sv =====
module fprs_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fprs_pkg::WORD_BITS-1:0]    op_a,
   input  logic [fprs_pkg::WORD_BITS-1:0]    op_b,
   output logic                              done,
   output logic [fprs_pkg::PROD_BITS-1:0]    product
);
   import fprs_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   logic [PROD_BITS-1:0] mcand_ff, mcand_in;
   logic [WORD_BITS-1:0] mplier_ff, mplier_in;
   logic [PROD_BITS-1:0] acc_ff, acc_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   // shift-add, one multiplier bit per cycle
   always_comb begin
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      acc_in = acc_ff;
      count_in = count_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         mcand_in = {{(PROD_BITS-WORD_BITS){1'b0}}, op_a};
         mplier_in = op_b;
         acc_in = '0;
         count_in = CNT_BITS'(WORD_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = {mcand_ff[PROD_BITS-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[WORD_BITS-1:1]};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_BITS'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff <= acc_in;
      count_ff <= count_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

// ===== src/fprs_div.sv =====
module fprs_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fprs_pkg::PROD_BITS-1:0]    dividend,
   input  logic [fprs_pkg::WORD_BITS:0]      divisor,
   output logic                              done,
   output logic [fprs_pkg::WORD_BITS-1:0]    quotient
);
   import fprs_pkg::*;

   localparam int CNT_BITS = $clog2(PROD_BITS + 1);
   localparam int REM_BITS = WORD_BITS + 2;

   logic [PROD_BITS-1:0] dvd_ff, dvd_in;
   logic [WORD_BITS:0]   dvs_ff, dvs_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [REM_BITS-1:0]  shifted;
   logic [REM_BITS-1:0]  trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      count_in = count_ff;
      run_in = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff[REM_BITS-2:0], dvd_ff[PROD_BITS-1]};
      trial = shifted - {1'b0, dvs_ff};
      if (start) begin
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
         count_in = CNT_BITS'(PROD_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[REM_BITS-1]) begin
            rem_in = trial;
         end else begin
            rem_in = shifted;
         end
         dvd_in = {dvd_ff[PROD_BITS-2:0], ~trial[REM_BITS-1]};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_BITS'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      count_ff <= count_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = dvd_ff[WORD_BITS-1:0];

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   import fprs_pkg::*;

   localparam int STALL_LIMIT = 6000;
   localparam int DRAIN_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = ACT_START;
   logic signed [31:0] req_bracket_low = '0;
   logic signed [31:0] req_bracket_high = '0;
   logic signed [31:0] req_f_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_kind;
   logic signed [31:0] rsp_point;
   logic [2:0] rsp_status;
   logic [15:0] rsp_iterations_done;
   logic [16:0] rsp_function_calls;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0] csr_paddr = '0;
   logic [DATA_BITS-1:0] csr_pwdata = '0;
   logic [DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   false_position_root_search_top DUT (.*);

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct {
      logic kind;
      logic [31:0] point;
      logic [2:0] status;
      logic [15:0] iters;
      logic [16:0] calls;
   } answer_type;

   // search predictor and expected answer store
   class root_search_board;
      answer_type pending[$];
      int errors;
      phase_type ph;
      longint end_a, end_b, val_a, val_b, probe_pt;
      int unsigned iter_cnt, call_cnt;
      longint unsigned abs_tol, rel_tol, iter_lim;
      longint last_point;

      function new();
         errors = 0;
         abs_tol = ABS_TOL_RESET;
         rel_tol = REL_TOL_RESET;
         iter_lim = ITER_LIMIT_RESET;
         ph = PH_IDLE;
         end_a = 0; end_b = 0; val_a = 0; val_b = 0; probe_pt = 0;
         iter_cnt = 0; call_cnt = 0; last_point = 0;
      endfunction

      function longint unsigned mag(longint v);
         return v < 0 ? longint'(-v) : v;
      endfunction

      function void push(logic kind, longint pt, logic [2:0] st);
         answer_type a;
         a.kind = kind;
         a.point = pt[31:0];
         a.status = st;
         a.iters = iter_cnt[15:0];
         a.calls = call_cnt[16:0];
         last_point = pt;
         pending.push_back(a);
      endfunction

      function void finish(longint pt, logic [2:0] st);
         ph = PH_IDLE;
         push(KIND_DONE, pt, st);
      endfunction

      // next interpolated point, rounded toward end_a
      function void probe();
         longint unsigned fa, fb, den, q;
         longint dx;
         fa = mag(val_a);
         fb = mag(val_b);
         den = fa + fb;
         dx = end_b - end_a;
         iter_cnt++;
         if (den == 0) begin
            probe_pt = end_a;
         end else begin
            q = (mag(dx) * fa) / den;
            probe_pt = dx < 0 ? end_a - longint'(q) : end_a + longint'(q);
         end
         call_cnt++;
         ph = PH_WAIT_M;
         push(KIND_PROBE, probe_pt, STAT_PROGRESS);
      endfunction

      function void note_item(logic act, logic signed [31:0] lo, logic signed [31:0] hi,
                              logic signed [31:0] f);
         longint fv;
         longint unsigned w;
         fv = f;
         if (act == ACT_START) begin
            end_a = lo; end_b = hi;
            val_a = 0; val_b = 0; probe_pt = 0;
            iter_cnt = 0; call_cnt = 1;
            ph = PH_WAIT_A;
            push(KIND_PROBE, end_a, STAT_PROGRESS);
            return;
         end
         case (ph)
            PH_WAIT_A: begin
               val_a = fv;
               call_cnt = 2;
               ph = PH_WAIT_B;
               push(KIND_PROBE, end_b, STAT_PROGRESS);
            end
            PH_WAIT_B: begin
               val_b = fv;
               if (val_a == 0) finish(end_a, STAT_CONVERGED);
               else if (val_b == 0) finish(end_b, STAT_CONVERGED);
               else if ((val_a < 0) == (val_b < 0)) finish(0, STAT_SIGN_ERROR);
               else if (iter_lim == 0) finish(end_a, STAT_NO_CONV);
               else probe();
            end
            PH_WAIT_M: begin
               if ((fv < 0) == (val_b < 0)) begin
                  end_b = probe_pt; val_b = fv;
               end else begin
                  end_a = probe_pt; val_a = fv;
               end
               w = mag(end_b - end_a);
               if (fv == 0 || w < abs_tol || (w << 16) < rel_tol * mag(probe_pt))
                  finish(probe_pt, STAT_CONVERGED);
               else if (iter_cnt >= iter_lim) finish(end_a, STAT_NO_CONV);
               else probe();
            end
            default: push(KIND_DONE, 0, STAT_ORDER);
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_answer(logic kind, logic [31:0] pt, logic [2:0] st, logic [15:0] it,
                        logic [16:0] calls);
         answer_type a;
         if (pending.size() == 0) begin
            report($sformatf("unexpected item kind %0d point %h", kind, pt));
            return;
         end
         a = pending.pop_front();
         if (kind !== a.kind) report($sformatf("kind %0d, expected %0d", kind, a.kind));
         if (pt !== a.point) report($sformatf("point %h, expected %h", pt, a.point));
         if (st !== a.status) report($sformatf("status %0d, expected %0d", st, a.status));
         if (it !== a.iters) report($sformatf("iterations %0d, expected %0d", it, a.iters));
         if (calls !== a.calls) report($sformatf("calls %0d, expected %0d", calls, a.calls));
      endtask
   endclass

   root_search_board board = new();

   // handshake sampling away from the active edge
   logic req_fire = 1'b0, rsp_fire = 1'b0, csr_ack = 1'b0;
   answer_type seen;
   always @(negedge clock) begin
      req_fire = req_valid && req_ready;
      rsp_fire = rsp_valid && rsp_ready;
      csr_ack = csr_pready;
      seen.kind = rsp_kind;
      seen.point = rsp_point;
      seen.status = rsp_status;
      seen.iters = rsp_iterations_done;
      seen.calls = rsp_function_calls;
   end

   // result checking and watchdog
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset && rsp_fire)
         board.check_answer(seen.kind, seen.point, seen.status, seen.iters, seen.calls);
      if (req_fire || rsp_fire) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver with random stalls and one long hold-off
   bit no_stall = 1'b0;
   bit hold_off = 1'b0;
   initial begin : receiver
      int stall;
      @(negedge reset);
      forever begin
         stall = no_stall ? 0 : $urandom_range(0, 11);
         if (hold_off) begin
            stall = 500;
            hold_off = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_fire);
      end
   end

   bit no_gaps = 1'b0;
   int sent = 0;

   task send_item(logic act, logic signed [31:0] lo, logic signed [31:0] hi,
                  logic signed [31:0] f);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_bracket_low <= lo;
      req_bracket_high <= hi;
      req_f_value <= f;
      do @(posedge clock); while (!req_fire);
      board.note_item(act, lo, hi, f);
      sent++;
   endtask

   task csr_write(logic [1:0] idx, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_ack);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_ABS_TOL: board.abs_tol = data[30:0];
         REG_REL_TOL: board.rel_tol = data[15:0];
         default: board.iter_lim = data[15:0];
      endcase
   endtask

   task drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // outside function to be solved, with a few shapes
   function logic signed [31:0] eval_f(longint x, longint root, int shape, bit flip);
      longint d, s, v;
      d = x - root;
      case (shape)
         0: v = d;
         1: v = d >>> 3;
         2: begin
            s = d >>> 10;
            v = (s * (s < 0 ? -s : s)) >>> 6;
         end
         default: v = d * 5;
      endcase
      return sat32(flip ? -v : v);
   endfunction

   // one search with well-formed answers, sometimes broken or cut short
   task run_search(logic signed [31:0] lo, logic signed [31:0] hi, longint root,
                   int shape, bit flip);
      send_item(ACT_START, lo, hi, $urandom);
      while (board.ph != PH_IDLE) begin
         if ($urandom_range(0, 99) < 3) return;
         if ($urandom_range(0, 99) < 5)
            send_item(ACT_VALUE, $urandom, $urandom, $urandom);
         else
            send_item(ACT_VALUE, $urandom, $urandom,
                      eval_f(board.last_point, root, shape, flip));
      end
   endtask

   task random_search();
      longint root, spread_a, spread_b;
      root = longint'(int'($urandom)) >>> $urandom_range(0, 16);
      spread_a = longint'($urandom_range(1, 32'h7fffffff)) >>> $urandom_range(0, 24);
      spread_b = longint'($urandom_range(1, 32'h7fffffff)) >>> $urandom_range(0, 24);
      if ($urandom_range(0, 1))
         run_search(sat32(root - spread_a), sat32(root + spread_b), root,
                    $urandom_range(0, 3), $urandom_range(0, 1));
      else
         run_search(sat32(root + spread_b), sat32(root - spread_a), root,
                    $urandom_range(0, 3), $urandom_range(0, 1));
   endtask

   task random_phase(int count);
      int stop_at;
      stop_at = sent + count;
      while (sent < stop_at) begin
         if ($urandom_range(0, 9) == 0)
            send_item($urandom_range(0, 1), $urandom, $urandom, $urandom);
         else
            random_search();
      end
   endtask

   // register settings, extremes among them
   logic [31:0] abs_set[6] = '{66, 0, 32'h7fffffff, 0, 65536, 0};
   logic [31:0] rel_set[6] = '{66, 0, 65535, 65535, 0, 0};
   logic [31:0] lim_set[6] = '{100, 1, 65535, 30, 300, 40};

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: value while idle, extreme brackets and values
      send_item(ACT_VALUE, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
      run_search(32'sh80000000, 32'sh7fffffff, 0, 0, 1'b0);
      send_item(ACT_START, 32'sh7fffffff, 32'sh80000000, 0);
      send_item(ACT_VALUE, 0, 0, 32'sh80000000);
      send_item(ACT_VALUE, 0, 0, 32'sh7fffffff);
      // zero at first end, zero at second end
      send_item(ACT_START, -32'sd65536, 32'sd65536, 0);
      send_item(ACT_VALUE, 0, 0, 0);
      send_item(ACT_VALUE, 0, 0, 5);
      send_item(ACT_START, -32'sd65536, 32'sd65536, 0);
      send_item(ACT_VALUE, 0, 0, 3);
      send_item(ACT_VALUE, 0, 0, 0);
      // same signs at the ends
      send_item(ACT_START, 1, 2, 0);
      send_item(ACT_VALUE, 0, 0, 7);
      send_item(ACT_VALUE, 0, 0, 9);
      send_item(ACT_START, 1, 2, 0);
      send_item(ACT_VALUE, 0, 0, -1);
      send_item(ACT_VALUE, 0, 0, 32'sh80000000);
      // restart while a search runs, then an exact root
      send_item(ACT_START, -32'sd100, 32'sd300, 0);
      send_item(ACT_VALUE, 0, 0, 1);
      run_search(-32'sd262144, 32'sd131072, 0, 0, 1'b0);
      drain();

      for (int p = 0; p < 6; p++) begin
         csr_write(REG_ABS_TOL, abs_set[p]);
         csr_write(REG_REL_TOL, rel_set[p]);
         csr_write(REG_ITER_LIMIT, lim_set[p]);
         no_gaps = (p == 3);
         no_stall = (p == 4);
         if (p == 2) begin
            hold_off = 1'b1;
            no_gaps = 1'b1;
         end
         random_phase(180);
         drain();
      end

      if (board.errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
